// ===== design/hbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman byte encoder package
// Item types, function codes and a helper function for the encoder.
// ----------------------------------------------------------------------------
package hbe_pkg;

  localparam int BYTE_BITS        = 8;
  localparam int PEND_W           = 7;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  symbol;
    logic [31:0] codeword;
    logic [5:0]  code_length;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_stream;
  } res_t;

  function automatic logic [PEND_W-1:0] pend_mask(input logic [2:0] n);
    logic [PEND_W-1:0] m;
    for (int i = 0; i < PEND_W; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

// ===== design/hbe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module hbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/huffman_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// Huffman byte encoder
// Table-driven packer of variable-length codes into an MSB-first byte stream.
//
//   Channel  Signals                     Direction  Content
//   cmd      cmd_valid, cmd_ready, cmd   in         load, encode or flush item
//   res      res_valid, res_ready, res   out        packed byte and last flag
//
// A load item is written into the code table in its accept cycle and the
// block is ready again in the next cycle. An encode item reads the table,
// emits zero to four bytes through the shifter, one byte per cycle, and
// closes; no new item is accepted before it is done. A flush item emits
// any pending bits as a last byte. Emission waits while the result
// register is full. The code table is not cleared by reset.
// ----------------------------------------------------------------------------
module huffman_byte_encoder
  import hbe_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int ENT_W = MAX_CODE_LEN + LEN_W;
  localparam int ACC_W = MAX_CODE_LEN + PEND_W;
  localparam int TOT_W = $clog2(MAX_CODE_LEN + PEND_W + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]        state;
  logic [PEND_W-1:0] pend;
  logic [2:0]        pcount;
  logic [ACC_W-1:0]  acc;
  logic [TOT_W-1:0]  total;

  logic                    accept;
  logic                    sym_ok;
  logic [LEN_W-1:0]        len_sat;
  logic [MAX_CODE_LEN-1:0] code_masked;
  logic                    we;
  logic                    re;
  logic [IDX_W-1:0]        addr;
  logic [ENT_W-1:0]        wdata;
  logic [ENT_W-1:0]        rdata;
  logic [LEN_W-1:0]        ent_len;
  logic [MAX_CODE_LEN-1:0] ent_code;
  logic                    slot_free;
  logic                    res_load;
  logic [7:0]              emit_byte;
  logic [7:0]              flush_byte;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign sym_ok    = (32'(cmd.symbol) < SYMBOL_COUNT);
  assign addr      = cmd.symbol[IDX_W-1:0];

  always_comb begin
    if (32'(cmd.code_length) > MAX_CODE_LEN) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = LEN_W'(cmd.code_length);
    end
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      code_masked[i] = cmd.codeword[i] && (i < int'(len_sat));
    end
  end

  assign wdata = {len_sat, code_masked};
  assign we    = accept && (cmd.func == FUNC_LOAD) && sym_ok;
  assign re    = accept && (cmd.func == FUNC_ENCODE) && sym_ok;

  hbe_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(wdata),
    .re   (re),
    .raddr(addr),
    .rdata(rdata)
  );

  assign ent_len    = rdata[ENT_W-1 -: LEN_W];
  assign ent_code   = rdata[MAX_CODE_LEN-1:0];
  assign slot_free  = !res_valid || res_ready;
  assign res_load   = slot_free &&
                      (((state == S_EMIT) && (total >= TOT_W'(BYTE_BITS))) ||
                       ((state == S_FLUSH) && (pcount != 3'd0)));
  assign emit_byte  = 8'(acc >> (total - TOT_W'(BYTE_BITS)));
  assign flush_byte = 8'({1'b0, pend} << (4'(BYTE_BITS) - {1'b0, pcount}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= '0;
      pcount    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (re) begin
            state <= S_READ;
          end else if (accept && (cmd.func == FUNC_FLUSH)) begin
            state <= S_FLUSH;
          end
        end
        S_READ: begin
          acc   <= (ACC_W'(pend) << ent_len) | ACC_W'(ent_code);
          total <= TOT_W'(pcount) + TOT_W'(ent_len);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (total >= TOT_W'(BYTE_BITS)) begin
            if (slot_free) begin
              res.out_byte       <= emit_byte;
              res.last_of_stream <= 1'b0;
              total              <= total - TOT_W'(BYTE_BITS);
            end
          end else begin
            pend   <= acc[PEND_W-1:0] & pend_mask(total[2:0]);
            pcount <= total[2:0];
            state  <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (pcount == 3'd0) begin
            pend  <= '0;
            state <= S_IDLE;
          end else if (slot_free) begin
            res.out_byte       <= flush_byte;
            res.last_of_stream <= 1'b1;
            pend               <= '0;
            pcount             <= '0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
